>>> hdl/ctet_pkg.sv
// ============================================================================
// Condition expression tokenizer package
// Shared widths, character codes, token kinds and the token record.
// ============================================================================
`default_nettype none

package ctet_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int POS_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int MAX_RES  = 3;
    localparam int CNT_W    = $clog2(MAX_RES + 1);
    localparam int Q_DEPTH  = 8;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);

    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        KIND_SYM    = 4'd0,
        KIND_OR     = 4'd1,
        KIND_AND    = 4'd2,
        KIND_EQ     = 4'd3,
        KIND_NE     = 4'd4,
        KIND_GE     = 4'd5,
        KIND_GT     = 4'd6,
        KIND_LE     = 4'd7,
        KIND_LT     = 4'd8,
        KIND_NOT    = 4'd9,
        KIND_LPAREN = 4'd10,
        KIND_RPAREN = 4'd11,
        KIND_END    = 4'd12
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              last;
        logic              overflow;
    } token_t;

    // Tokens produced by one accepted word, slot 0 first.
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        token_t [MAX_RES-1:0]     tok;
    } push_t;

    function automatic token_t make_token(kind_t k, logic [POS_W-1:0] s,
                                          logic [LEN_W-1:0] l);
        token_t t;
        t.kind     = k;
        t.start    = s;
        t.length   = l;
        t.last     = 1'b0;
        t.overflow = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ctet_front.sv
// ============================================================================
// Tokenizer front end
// Holds the scan state and turns one input word into up to three tokens.
// ============================================================================
`default_nettype none

module ctet_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     char_byte,
    input  wire logic           final_byte,
    input  wire logic           room,
    output ctet_pkg::push_t     push
);
    import ctet_pkg::*;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_BAR  = 3'd1,
        OP_AMP  = 3'd2,
        OP_EQS  = 3'd3,
        OP_BANG = 3'd4,
        OP_GT   = 3'd5,
        OP_LT   = 3'd6
    } op_t;

    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] sym_start_reg, sym_start_next;
    logic [LEN_W-1:0] sym_len_reg, sym_len_next;
    op_t              pend_op_reg, pend_op_next;
    logic [POS_W-1:0] pend_start_reg, pend_start_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic             ovf_out;
    logic [POS_W-1:0] end_pos;

    token_t [MAX_RES-1:0] toks;
    logic [CNT_W-1:0]     cnt;

    assign in_ready = room;
    assign accept   = in_valid && room;
    assign ovf_out  = ovf_reg || (!final_byte && (position_reg == POS_MAX));
    assign end_pos  = (position_reg == POS_MAX) ? POS_MAX : position_reg + POS_W'(1);

    always_comb begin
        logic [POS_W-1:0] ss;
        logic [LEN_W-1:0] sl;
        op_t              po;
        logic [POS_W-1:0] ps;
        logic             consumed;
        logic [7:0]       want;
        kind_t            pk;

        ss       = sym_start_reg;
        sl       = sym_len_reg;
        po       = pend_op_reg;
        ps       = pend_start_reg;
        consumed = 1'b0;
        cnt      = '0;
        toks     = '0;
        want     = CH_BAR;
        pk       = KIND_OR;

        // Pairing of a held operator with this byte.
        if (po == OP_BAR || po == OP_AMP || po == OP_EQS) begin
            case (po)
                OP_BAR:  begin want = CH_BAR; pk = KIND_OR;  end
                OP_AMP:  begin want = CH_AMP; pk = KIND_AND; end
                default: begin want = CH_EQ;  pk = KIND_EQ;  end
            endcase
            if (char_byte == want) begin
                if (sl != '0) begin
                    toks[cnt[1:0]] = make_token(KIND_SYM, ss, sl);
                    cnt = cnt + CNT_W'(1);
                    sl = '0;
                end
                toks[cnt[1:0]] = make_token(pk, ps, LEN_W'(2));
                cnt = cnt + CNT_W'(1);
                po = OP_NONE;
                consumed = 1'b1;
            end
        end else if (po != OP_NONE) begin
            case (po)
                OP_BANG: pk = KIND_NE;
                OP_GT:   pk = KIND_GE;
                default: pk = KIND_LE;
            endcase
            if (char_byte == CH_EQ) begin
                toks[cnt[1:0]] = make_token(pk, ps, LEN_W'(2));
                cnt = cnt + CNT_W'(1);
                po = OP_NONE;
                consumed = 1'b1;
            end
        end

        if (!consumed) begin
            // A held operator that did not pair resolves as a single byte.
            case (po)
                OP_BAR, OP_AMP, OP_EQS: begin
                    if (sl == '0) ss = ps;
                    if (sl < LEN_W'(MAX_LEN)) sl = sl + LEN_W'(1);
                end
                OP_BANG: begin
                    toks[cnt[1:0]] = make_token(KIND_NOT, ps, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                OP_GT: begin
                    toks[cnt[1:0]] = make_token(KIND_GT, ps, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                OP_LT: begin
                    toks[cnt[1:0]] = make_token(KIND_LT, ps, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                default: ;
            endcase
            po = OP_NONE;

            case (char_byte) inside
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                    if (sl != '0) begin
                        toks[cnt[1:0]] = make_token(KIND_SYM, ss, sl);
                        cnt = cnt + CNT_W'(1);
                        sl = '0;
                    end
                end
                CH_BAR: begin po = OP_BAR; ps = position_reg; end
                CH_AMP: begin po = OP_AMP; ps = position_reg; end
                CH_EQ:  begin po = OP_EQS; ps = position_reg; end
                CH_BANG, CH_GT, CH_LT: begin
                    if (sl != '0) begin
                        toks[cnt[1:0]] = make_token(KIND_SYM, ss, sl);
                        cnt = cnt + CNT_W'(1);
                        sl = '0;
                    end
                    case (char_byte)
                        CH_BANG: po = OP_BANG;
                        CH_GT:   po = OP_GT;
                        default: po = OP_LT;
                    endcase
                    ps = position_reg;
                end
                CH_LPAREN, CH_RPAREN: begin
                    if (sl != '0) begin
                        toks[cnt[1:0]] = make_token(KIND_SYM, ss, sl);
                        cnt = cnt + CNT_W'(1);
                        sl = '0;
                    end
                    toks[cnt[1:0]] = make_token((char_byte == CH_LPAREN) ? KIND_LPAREN
                                                                         : KIND_RPAREN,
                                                position_reg, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                default: begin
                    if (sl == '0) ss = position_reg;
                    if (sl < LEN_W'(MAX_LEN)) sl = sl + LEN_W'(1);
                end
            endcase
        end

        if (final_byte) begin
            // End of expression: resolve, flush, then the end marker.
            case (po)
                OP_BAR, OP_AMP, OP_EQS: begin
                    if (sl == '0) ss = ps;
                    if (sl < LEN_W'(MAX_LEN)) sl = sl + LEN_W'(1);
                end
                OP_BANG: begin
                    toks[cnt[1:0]] = make_token(KIND_NOT, ps, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                OP_GT: begin
                    toks[cnt[1:0]] = make_token(KIND_GT, ps, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                OP_LT: begin
                    toks[cnt[1:0]] = make_token(KIND_LT, ps, LEN_W'(1));
                    cnt = cnt + CNT_W'(1);
                end
                default: ;
            endcase
            po = OP_NONE;
            if (sl != '0) begin
                toks[cnt[1:0]] = make_token(KIND_SYM, ss, sl);
                cnt = cnt + CNT_W'(1);
                sl = '0;
            end
            if (cnt != CNT_W'(MAX_RES)) begin
                toks[cnt[1:0]] = make_token(KIND_END, end_pos, '0);
                cnt = cnt + CNT_W'(1);
            end
        end

        for (int i = 0; i < MAX_RES; i++) begin
            toks[i].overflow = ovf_out;
            toks[i].last     = (CNT_W'(i + 1) == cnt);
        end

        sym_start_next  = ss;
        sym_len_next    = sl;
        pend_op_next    = po;
        pend_start_next = ps;
    end

    always_comb begin
        push.tok = toks;
        push.cnt = accept ? cnt : '0;
    end

    always_comb begin
        position_next = position_reg;
        ovf_next      = ovf_reg;
        if (!final_byte) begin
            if (position_reg == POS_MAX) ovf_next = 1'b1;
            else position_next = position_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            sym_start_reg  <= '0;
            sym_len_reg    <= '0;
            pend_op_reg    <= OP_NONE;
            pend_start_reg <= '0;
            ovf_reg        <= 1'b0;
        end else if (accept) begin
            if (final_byte) begin
                position_reg   <= '0;
                sym_start_reg  <= '0;
                sym_len_reg    <= '0;
                pend_op_reg    <= OP_NONE;
                pend_start_reg <= '0;
                ovf_reg        <= 1'b0;
            end else begin
                position_reg   <= position_next;
                sym_start_reg  <= sym_start_next;
                sym_len_reg    <= sym_len_next;
                pend_op_reg    <= pend_op_next;
                pend_start_reg <= pend_start_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ctet_queue.sv
// ============================================================================
// Token queue
// Takes up to three tokens per cycle from the front end while it has room, and hands out one.
// ============================================================================
`default_nettype none

module ctet_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  ctet_pkg::push_t       push,
    output logic                  room,
    output logic                  q_valid,
    output ctet_pkg::token_t      q_tok,
    input  wire logic             q_pop
);
    import ctet_pkg::*;

    token_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_pop;

    assign room    = (count_reg <= Q_CNT_W'(Q_DEPTH - MAX_RES));
    assign q_valid = (count_reg != '0);
    assign q_tok   = mem_reg[rd_ptr_reg];
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(do_pop);
        count_next  = count_reg + Q_CNT_W'(push.cnt) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (CNT_W'(i) < push.cnt) begin
                mem_reg[wr_ptr_reg + Q_PTR_W'(i)] <= push.tok[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ctet_out.sv
// ============================================================================
// Token output stage
// Registered result word, refilled from the queue whenever it empties or moves.
// ============================================================================
`default_nettype none

module ctet_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  ctet_pkg::token_t       q_tok,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ctet_pkg::token_t       out_tok
);
    import ctet_pkg::*;

    logic   valid_reg, valid_next;
    token_t tok_reg;

    assign q_pop      = q_valid && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_tok    = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) tok_reg <= q_tok;
    end

endmodule

`default_nettype wire

>>> hdl/condition_expression_tokenizer_unit.sv
// ============================================================================
// Condition expression tokenizer
// Splits a byte stream of condition expressions into symbol and operator tokens.
// ============================================================================
// Usage: one character arrives per word on the s_ channel, with s_final_byte
// set on the last character of an expression. Each accepted word yields zero
// to three tokens on the m_ channel; each token word carries its kind, start
// position and length, m_run_last on the last token caused by that input
// word, and the sticky position overflow flag.
// Throughput: one input word per cycle as long as the token queue has room
// for three more tokens. The output channel moves one token per cycle while
// m_ready is high, so a burst of tokens is absorbed by the eight-entry queue
// between the front end and the output register.
// Path: the first token of a word enters the queue at the edge that accepts
// the word and then the output register, when the queue is empty and the
// output register is free; later tokens of the same word follow one per cycle.
// Stalls: when m_ready stays low the output register holds its word, the
// queue fills, and s_ready falls once fewer than three entries are free.
// Reset: synchronous active-low aresetn clears the scan position, the pending
// symbol and operator, the overflow flag, the queue and the output register.
// After the final byte of an expression the scan state returns to reset.
// ============================================================================
`default_nettype none

module condition_expression_tokenizer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_token_kind,
    output logic [11:0]      m_token_start,
    output logic [12:0]      m_token_length,
    output logic             m_run_last,
    output logic             m_overflow
);
    import ctet_pkg::*;

    push_t  push;
    logic   room;
    logic   q_valid;
    token_t q_tok;
    logic   q_pop;
    token_t out_tok;

    // Front end: scan state and token generation for each accepted byte.
    ctet_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .char_byte  (s_char_byte),
        .final_byte (s_final_byte),
        .room       (room),
        .push       (push)
    );

    // Queue decouples token bursts from the one-per-cycle output.
    ctet_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .q_valid (q_valid),
        .q_tok   (q_tok),
        .q_pop   (q_pop)
    );

    // Output register drives the result channel.
    ctet_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_tok     (q_tok),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_tok   (out_tok)
    );

    assign m_token_kind   = out_tok.kind;
    assign m_token_start  = out_tok.start;
    assign m_token_length = out_tok.length;
    assign m_run_last     = out_tok.last;
    assign m_overflow     = out_tok.overflow;

endmodule

`default_nettype wire
